// File: sv/npat_pkg.sv
// ----------------------------------------------------------------------------
// npat_pkg
// shared types, widths and constants of the node presence aging table
// ----------------------------------------------------------------------------
package npat_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned POWER_W  = 11;
  localparam int unsigned TICK_W   = 29;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [TIME_W-1:0] EXPIRY_RESET = TIME_W'(45000);

  // power = 3 * code - 93, wrapped to the power width
  localparam int unsigned POWER_STEP   = 3;
  localparam int unsigned POWER_OFFSET = 93;

  // age / 10 as (age * ceil(2^35 / 10)) >> 35, exact for every 32-bit age
  localparam logic [TIME_W-1:0] TICK_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned       TICK_SHIFT = 35;

  localparam logic MODE_REPORT = 1'b0;
  localparam logic MODE_SWEEP  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  stamp;
    logic [POWER_W-1:0] power;
  } entry_t;

  function automatic logic [POWER_W-1:0] power_of(input logic [CODE_W-1:0] code);
    logic [POWER_W-1:0] scaled;
    scaled = POWER_W'(code) * POWER_W'(POWER_STEP);
    return scaled - POWER_W'(POWER_OFFSET);
  endfunction

endpackage

// File: sv/npat_if.sv
// ----------------------------------------------------------------------------
// npat_if
// valid/ready channels for report and sweep items and for listed entries
// ----------------------------------------------------------------------------
interface npat_in_if
  import npat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ID_W-1:0]   node_id;
  logic [CODE_W-1:0] rssi_code;
  logic [TIME_W-1:0] now_ms;
  logic              link_up;

  modport source (output valid, output mode, output node_id, output rssi_code,
                  output now_ms, output link_up, input ready);
  modport sink   (input valid, input mode, input node_id, input rssi_code,
                  input now_ms, input link_up, output ready);
endinterface

interface npat_out_if
  import npat_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      valid_res;
  logic [ID_W-1:0]           out_node_id;
  logic [TICK_W-1:0]         age_ticks;
  logic signed [POWER_W-1:0] power_db;
  logic [COUNT_W-1:0]        live_count;
  logic                      link_state;
  logic                      last;

  modport source (output valid, output valid_res, output out_node_id,
                  output age_ticks, output power_db, output live_count,
                  output link_state, output last, input ready);
  modport sink   (input valid, input valid_res, input out_node_id,
                  input age_ticks, input power_db, input live_count,
                  input link_state, input last, output ready);
endinterface

// File: sv/node_presence_aging_table_top.sv
// ----------------------------------------------------------------------------
// node_presence_aging_table_top
// table of heard nodes in arrival order with refresh, aging sweep and listing
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    mode, node_id, rssi_code, now_ms, link_up
//  out_o     out  valid/ready    valid_res, out_node_id, age_ticks, power_db,
//                                live_count, link_state, last
//  cfg       in   cfg_we_i       cfg_wdata_i -> expiry_ms
//
//  a report reads the table one entry per cycle through the single read port
//  a sweep compacts the table, then lists each entry in the steps ram read,
//  age, multiply and load through the shared age unit; an empty sweep gives
//  its one result after compaction
//  after reset the table is empty; no clearing pass
//  in_i is ready only when idle; a waiting result holds the listing back
// ----------------------------------------------------------------------------
module node_presence_aging_table_top
  import npat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  npat_in_if.sink           in_i,
  npat_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_EMPTY,
    S_LRD,
    S_LAGE,
    S_LMUL,
    S_LOUT
  } state_e;

  state_e             state_q;
  logic [TIME_W-1:0]  expiry_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      rd_idx_q;
  logic [CW-1:0]      wr_idx_q;
  logic [AW-1:0]      ev_idx_q;
  logic               ev_vld_q;
  logic [ID_W-1:0]    id_q;
  logic [TIME_W-1:0]  now_q;
  logic [POWER_W-1:0] pow_q;
  logic               link_q;
  logic [ID_W-1:0]    lst_id_q;
  logic [POWER_W-1:0] lst_pow_q;

  logic                      out_vld_q;
  logic                      out_res_q;
  logic [ID_W-1:0]           out_id_q;
  logic [TICK_W-1:0]         out_ticks_q;
  logic signed [POWER_W-1:0] out_pow_q;
  logic [COUNT_W-1:0]        out_live_q;
  logic                      out_link_q;
  logic                      out_last_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic              alive;
  logic [TICK_W-1:0] ticks;
  logic              match;
  logic              more;
  logic              room;
  logic [CW-1:0]     rd_next;

  assign match   = ev_vld_q && (ram_rdata.id == id_q);
  assign more    = rd_idx_q < count_q;
  assign room    = count_q < CW'(TABLE_DEPTH);
  assign rd_next = rd_idx_q + CW'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_q;
    ram_wdata = '{id: id_q, stamp: now_q, power: pow_q};
    ram_re    = 1'b0;
    ram_raddr = rd_idx_q[AW-1:0];
    case (state_q)
      S_SCAN: begin
        if (match) begin
          ram_we = 1'b1;
        end else if (more) begin
          ram_re = 1'b1;
        end else if (!ev_vld_q && room) begin
          // new node goes to the end of the table
          ram_we    = 1'b1;
          ram_waddr = count_q[AW-1:0];
        end
      end
      S_COMPACT: begin
        // write slot never passes the read slot, so order is kept
        ram_we    = ev_vld_q && alive;
        ram_waddr = wr_idx_q[AW-1:0];
        ram_wdata = ram_rdata;
        ram_re    = more;
      end
      S_LRD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  npat_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  npat_age_unit u_age (
    .clk_i    (clk_i),
    .now_i    (now_q),
    .stamp_i  (ram_rdata.stamp),
    .expiry_i (expiry_q),
    .age_en_i (state_q == S_LAGE),
    .mul_en_i (state_q == S_LMUL),
    .alive_o  (alive),
    .ticks_o  (ticks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q  <= EXPIRY_RESET;
      state_q   <= S_IDLE;
      count_q   <= '0;
      rd_idx_q  <= '0;
      wr_idx_q  <= '0;
      ev_idx_q  <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            id_q     <= in_i.node_id;
            now_q    <= in_i.now_ms;
            pow_q    <= power_of(in_i.rssi_code);
            link_q   <= in_i.link_up;
            rd_idx_q <= '0;
            wr_idx_q <= '0;
            ev_vld_q <= 1'b0;
            state_q  <= (in_i.mode == MODE_SWEEP) ? S_COMPACT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            state_q <= S_IDLE;
          end else if (more) begin
            rd_idx_q <= rd_next;
            ev_idx_q <= rd_idx_q[AW-1:0];
            ev_vld_q <= 1'b1;
          end else if (ev_vld_q) begin
            ev_vld_q <= 1'b0;
          end else begin
            if (room) begin
              count_q <= count_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_COMPACT: begin
          if (ev_vld_q && alive) begin
            wr_idx_q <= wr_idx_q + CW'(1);
          end
          if (more) begin
            rd_idx_q <= rd_next;
            ev_idx_q <= rd_idx_q[AW-1:0];
            ev_vld_q <= 1'b1;
          end else begin
            ev_vld_q <= 1'b0;
          end
          if (!ev_vld_q && !more) begin
            count_q  <= wr_idx_q;
            rd_idx_q <= '0;
            state_q  <= (wr_idx_q == '0) ? S_EMPTY : S_LRD;
          end
        end
        S_EMPTY: begin
          if (!out_vld_q) begin
            out_vld_q   <= 1'b1;
            out_res_q   <= 1'b0;
            out_id_q    <= '0;
            out_ticks_q <= '0;
            out_pow_q   <= '0;
            out_live_q  <= '0;
            out_link_q  <= link_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_LRD: begin
          state_q <= S_LAGE;
        end
        S_LAGE: begin
          lst_id_q  <= ram_rdata.id;
          lst_pow_q <= ram_rdata.power;
          state_q   <= S_LMUL;
        end
        S_LMUL: begin
          state_q <= S_LOUT;
        end
        S_LOUT: begin
          if (!out_vld_q) begin
            out_vld_q   <= 1'b1;
            out_res_q   <= 1'b1;
            out_id_q    <= lst_id_q;
            out_ticks_q <= ticks;
            out_pow_q   <= $signed(lst_pow_q);
            out_live_q  <= COUNT_W'(count_q);
            out_link_q  <= link_q;
            out_last_q  <= (rd_next == count_q);
            rd_idx_q    <= rd_next;
            state_q     <= (rd_next == count_q) ? S_IDLE : S_LRD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_vld_q;
  assign out_o.valid_res   = out_res_q;
  assign out_o.out_node_id = out_id_q;
  assign out_o.age_ticks   = out_ticks_q;
  assign out_o.power_db    = out_pow_q;
  assign out_o.live_count  = out_live_q;
  assign out_o.link_state  = out_link_q;
  assign out_o.last        = out_last_q;

endmodule

// File: sv/npat_entry_ram.sv
// ----------------------------------------------------------------------------
// npat_entry_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module npat_entry_ram
  import npat_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/npat_age_unit.sv
// ----------------------------------------------------------------------------
// npat_age_unit
// shared age arithmetic: wrapped age, expiry compare and tick conversion
// ----------------------------------------------------------------------------
module npat_age_unit
  import npat_pkg::*;
(
  input  logic              clk_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] stamp_i,
  input  logic [TIME_W-1:0] expiry_i,
  input  logic              age_en_i,
  input  logic              mul_en_i,
  output logic              alive_o,
  output logic [TICK_W-1:0] ticks_o
);

  logic [TIME_W-1:0]   age;
  logic [TIME_W-1:0]   age_q;
  logic [2*TIME_W-1:0] prod_q;

  assign age     = now_i - stamp_i;
  assign alive_o = age < expiry_i;

  always_ff @(posedge clk_i) begin
    if (age_en_i) begin
      age_q <= age;
    end
    if (mul_en_i) begin
      prod_q <= age_q * TICK_RECIP;
    end
  end

  assign ticks_o = prod_q[TICK_SHIFT +: TICK_W];

endmodule
